### hdl/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C bit-level master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Operation codes on the command channel
    localparam logic [2:0] OP_START     = 3'd0;
    localparam logic [2:0] OP_STOP      = 3'd1;
    localparam logic [2:0] OP_WRITE     = 3'd2;
    localparam logic [2:0] OP_READ_ACK  = 3'd3;
    localparam logic [2:0] OP_READ_NACK = 3'd4;

    // Configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_POLL_LIMIT  = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd500;
    localparam logic [7:0]  POLL_LIMIT_RST  = 8'd10;
    localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } t_cmd;

    // One classified tick
    typedef struct packed {
        t_cmd       cmd;
        logic       ack;
        logic [7:0] wdata;
        logic       sda;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef enum logic [13:0] {
        PH_IDLE   = 14'b00000000000001,
        PH_ST1    = 14'b00000000000010,
        PH_ST2    = 14'b00000000000100,
        PH_ST3    = 14'b00000000001000,
        PH_SP1    = 14'b00000000010000,
        PH_SP2    = 14'b00000000100000,
        PH_WSET   = 14'b00000001000000,
        PH_WHIGH  = 14'b00000010000000,
        PH_WLOW   = 14'b00000100000000,
        PH_AKLOW  = 14'b00001000000000,
        PH_AKHIGH = 14'b00010000000000,
        PH_RLOW   = 14'b00100000000000,
        PH_RHIGH  = 14'b01000000000000,
        PH_SAHIGH = 14'b10000000000000
    } t_phase;

endpackage
`default_nettype wire

### hdl/i2cm_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_cmd_if
// Tick channel into the master: optional command plus sampled SDA.
// ----------------------------------------------------------------------------
interface i2cm_cmd_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, output cmd_valid, output operation,
                    output write_data, output sda_in, input ready);
    modport sink   (input valid, input cmd_valid, input operation,
                    input write_data, input sda_in, output ready);
endinterface
`default_nettype wire

### hdl/i2cm_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_res_if
// Result channel out of the master: bus drive levels and status per tick.
// ----------------------------------------------------------------------------
interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output read_data, output nack, input ready);
    modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                    input done_res, input read_data, input nack, output ready);
endinterface
`default_nettype wire

### hdl/i2cm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick beats, classifies the command and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    i2cm_cmd_if.sink   i_cmd,
    input  wire logic  i_pop,
    output t_queue_head o_head
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    t_item          w_item;
    logic           w_push;

    // Undefined operations and idle ticks both become CMD_NONE
    always_comb begin
        w_item.cmd   = CMD_NONE;
        w_item.ack   = 1'b0;
        w_item.wdata = i_cmd.write_data;
        w_item.sda   = i_cmd.sda_in;
        if (i_cmd.cmd_valid) begin
            case (i_cmd.operation)
                OP_START:     w_item.cmd = CMD_START;
                OP_STOP:      w_item.cmd = CMD_STOP;
                OP_WRITE:     w_item.cmd = CMD_WRITE;
                OP_READ_ACK: begin
                    w_item.cmd = CMD_READ;
                    w_item.ack = 1'b1;
                end
                OP_READ_NACK: w_item.cmd = CMD_READ;
                default:      w_item.cmd = CMD_NONE;
            endcase
        end
    end

    assign i_cmd.ready = (r_count != CW'(DEPTH));
    assign w_push      = i_cmd.valid && i_cmd.ready;
    assign o_head      = {(r_count != '0), r_mem[r_rd_ptr]};

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

### hdl/i2cm_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_engine
// Phase sequencer: one queued tick per cycle to the result register unless held.
// ----------------------------------------------------------------------------
module i2cm_engine import i2cm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire t_queue_head i_head,
    output logic             o_pop,
    i2cm_res_if.source       o_res
);
    logic [15:0] r_half;
    logic [7:0]  r_poll_limit;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_tick, n_tick;
    logic [7:0]  r_poll, n_poll;
    logic        r_ack_mode, n_ack_mode;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_nack, n_nack;
    logic [7:0]  r_read_hold, n_read_hold;
    logic        n_done;

    logic        r_out_valid;
    logic        r_scl_o, r_sda_o, r_busy_o, r_done_o, r_nack_o;
    logic [7:0]  r_read_o;

    logic [15:0] w_half, w_tick_inc;
    logic [3:0]  w_bits_inc;
    logic [7:0]  w_shl, w_rd_shift;
    t_item       w_it;

    assign w_half     = (r_half == '0) ? 16'd1 : r_half;
    assign w_tick_inc = r_tick + 16'd1;
    assign w_bits_inc = r_bit_count + 4'd1;
    assign w_shl      = {r_shift[6:0], 1'b0};
    assign w_it       = i_head.item;
    assign w_rd_shift = {r_shift[6:0], w_it.sda};

    assign o_pop = i_head.valid && (!r_out_valid || o_res.ready);

    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_tick      = r_tick;
        n_poll      = r_poll;
        n_ack_mode  = r_ack_mode;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_nack      = r_nack;
        n_read_hold = r_read_hold;
        n_done      = 1'b0;
        if (r_phase == PH_IDLE) begin
            case (w_it.cmd)
                CMD_START: begin
                    n_phase = PH_ST1; n_scl = 1'b1; n_sda = 1'b1; n_tick = '0;
                end
                CMD_STOP: begin
                    n_phase = PH_SP1; n_scl = 1'b1; n_sda = 1'b0; n_tick = '0;
                end
                CMD_WRITE: begin
                    n_shift = w_it.wdata; n_bit_count = '0;
                    n_phase = PH_WSET; n_scl = 1'b0; n_sda = w_it.wdata[7]; n_tick = '0;
                end
                CMD_READ: begin
                    n_shift = '0; n_bit_count = '0; n_ack_mode = w_it.ack;
                    n_phase = PH_RLOW; n_scl = 1'b0; n_sda = 1'b1; n_tick = '0;
                end
                default: ;
            endcase
        end else if (w_tick_inc < w_half) begin
            n_tick = w_tick_inc;
        end else begin
            // Half period reached: apply the next levels
            n_tick = '0;
            case (r_phase)
                PH_ST1: begin n_phase = PH_ST2; n_scl = 1'b1; n_sda = 1'b0; end
                PH_ST2: begin n_phase = PH_ST3; n_scl = 1'b0; n_sda = 1'b0; end
                PH_ST3: begin
                    n_phase = PH_IDLE; n_scl = 1'b0; n_sda = 1'b0; n_done = 1'b1;
                end
                PH_SP1: begin n_phase = PH_SP2; n_scl = 1'b1; n_sda = 1'b1; end
                PH_SP2: begin
                    n_phase = PH_IDLE; n_scl = 1'b1; n_sda = 1'b1; n_done = 1'b1;
                end
                PH_WSET:  begin n_phase = PH_WHIGH; n_scl = 1'b1; end
                PH_WHIGH: begin n_phase = PH_WLOW;  n_scl = 1'b0; end
                PH_WLOW: begin
                    n_shift     = w_shl;
                    n_bit_count = w_bits_inc;
                    n_scl       = 1'b0;
                    if (w_bits_inc < BITS_PER_BYTE) begin
                        n_phase = PH_WSET; n_sda = w_shl[7];
                    end else begin
                        n_phase = PH_AKLOW; n_sda = 1'b1;
                    end
                end
                PH_AKLOW: begin
                    n_poll = r_poll_limit; n_phase = PH_AKHIGH; n_scl = 1'b1; n_sda = 1'b1;
                end
                PH_AKHIGH: begin
                    if (r_poll == '0) begin
                        // Out of polls: flag nack and drive a stop
                        n_nack = 1'b1; n_phase = PH_SP1; n_scl = 1'b1; n_sda = 1'b0;
                    end else if (!w_it.sda) begin
                        n_nack = 1'b0; n_phase = PH_IDLE; n_scl = 1'b0; n_sda = 1'b1;
                        n_done = 1'b1;
                    end else begin
                        n_poll = r_poll - 8'd1;
                    end
                end
                PH_RLOW: begin n_phase = PH_RHIGH; n_scl = 1'b1; n_sda = 1'b1; end
                PH_RHIGH: begin
                    n_shift     = w_rd_shift;
                    n_bit_count = w_bits_inc;
                    if (w_bits_inc < BITS_PER_BYTE) begin
                        n_phase = PH_RLOW; n_scl = 1'b0; n_sda = 1'b1;
                    end else begin
                        n_read_hold = w_rd_shift;
                        n_phase = PH_SAHIGH; n_scl = 1'b1; n_sda = !r_ack_mode;
                    end
                end
                PH_SAHIGH: begin
                    n_phase = PH_IDLE; n_scl = 1'b0; n_sda = r_ack_mode; n_done = 1'b1;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half       <= HALF_PERIOD_RST;
            r_poll_limit <= POLL_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_half       <= i_cfg_wdata;
                CFG_POLL_LIMIT:  r_poll_limit <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_tick      <= '0;
            r_poll      <= '0;
            r_ack_mode  <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_nack      <= 1'b0;
            r_read_hold <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
                r_shift     <= n_shift;
                r_tick      <= n_tick;
                r_poll      <= n_poll;
                r_ack_mode  <= n_ack_mode;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_nack      <= n_nack;
                r_read_hold <= n_read_hold;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_scl_o  <= n_scl;
            r_sda_o  <= n_sda;
            r_busy_o <= (n_phase != PH_IDLE);
            r_done_o <= n_done;
            r_read_o <= n_read_hold;
            r_nack_o <= n_nack;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_out   = r_scl_o;
    assign o_res.sda_out   = r_sda_o;
    assign o_res.busy_res  = r_busy_o;
    assign o_res.done_res  = r_done_o;
    assign o_res.read_data = r_read_o;
    assign o_res.nack      = r_nack_o;
endmodule
`default_nettype wire

### hdl/i2c_bit_level_master.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// I2C master bit engine fed one tick beat per clock unless o_res is held.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one beat per bus tick: an optional command (start, stop,
//   write byte, read with ack, read with nack) and the sampled SDA level.
//   o_res returns exactly one beat per tick beat: SCL/SDA drive levels,
//   busy, a done pulse, the last read byte and the nack flag.
//   Config port: i_cfg_index 0 = half period in ticks, 1 = ack poll limit.
//   Write it only while the engine is idle.
// Timing:
//   One tick beat per cycle sustained while o_res is not held. A beat is
//   queued at acceptance, then stepped by the phase sequencer into the
//   result register, which drives o_res. The phase sequencer takes one
//   beat per unstalled cycle; the result register is the only output stage.
// Reset:
//   Idle, SCL and SDA released, half period 500, poll limit 10, flags clear.
// Stall:
//   When o_res is held, the result register keeps its beat, the queue fills
//   (QUEUE_DEPTH beats) and i_cmd.ready then drops until o_res drains.
// ----------------------------------------------------------------------------
module i2c_bit_level_master import i2cm_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    i2cm_cmd_if.sink         i_cmd,
    i2cm_res_if.source       o_res,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata
);
    t_queue_head w_head;
    logic        w_pop;

    i2cm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    i2cm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_res       (o_res)
    );

`ifndef SYNTH
    // A completing beat always leaves the engine idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.done_res |-> !o_res.busy_res)
        else $error("done beat reported busy");

    // The engine only steps a beat the queue actually holds
    a_pop_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("engine popped an empty queue");

    // The front only backs up after the result side stalled
    a_full_after_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.ready |-> $past(o_res.valid && !o_res.ready))
        else $error("front full without a result stall");
`endif
endmodule
`default_nettype wire
